>>> design/pcda_pkg.sv
// Shared constants, codes and controller/datapath interface types for the dimension algebra unit.
`timescale 1ns / 1ps
package pcda_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int MAX_BASES   = 16;
   localparam int PRIME_WIDTH = 16;
   localparam int HALF_WIDTH  = VALUE_WIDTH / 2;
   localparam int CNT_W       = $clog2(MAX_BASES + 1);
   localparam int IDX_W       = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;
   localparam int EXP_W       = 7;
   localparam int DCNT_W      = $clog2(VALUE_WIDTH + 1);

   typedef enum logic [1:0] {
      OP_NEW_BASE = 2'd0,
      OP_MUL      = 2'd1,
      OP_DIV      = 2'd2,
      OP_POW      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;        // capture request
      logic       cand_init;   // first candidate above last prime
      logic       cand_next;   // next candidate
      logic       idx_clr;
      logic       idx_inc;
      logic       mul_start;
      logic       mul_sel_d;   // 0: n*mn into n, 1: d*md into d
      logic       iter_inc;
      logic       div_start;   // divide n and d by table entry at idx
      logic       div_take;    // keep quotients
      logic       swap;
      logic       set_unit;    // 1/1
      logic       prime_store;
      logic       out_load;
      status_type out_code;
   } pcda_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic table_full;
      logic idx_end;
      logic both_zero;
      logic exp_zero;
      logic exp_one;
      logic iter_end;
      logic neg;
      logic mul_done;
      logic mul_ovf;
      logic div_done;
      logic rem_n_zero;
      logic rem_d_zero;
   } pcda_sts_type;

endpackage

>>> design/pcda_datapath.sv
// Datapath: operand registers, prime table, split multiplier and dual serial divider.
`timescale 1ns / 1ps
module pcda_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  pcda_pkg::pcda_cmd_type              cmd,
   output pcda_pkg::pcda_sts_type              sts,
   input  logic [1:0]                          req_opcode,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_num_a,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_den_a,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_num_b,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_den_b,
   input  logic signed [pcda_pkg::EXP_W-1:0]   req_exponent,
   output logic [pcda_pkg::VALUE_WIDTH-1:0]    rsp_num_out,
   output logic [pcda_pkg::VALUE_WIDTH-1:0]    rsp_den_out,
   output logic [1:0]                          rsp_status
);
   import pcda_pkg::*;

   localparam int VW = VALUE_WIDTH;
   localparam int PW = PRIME_WIDTH;

   // Working values and multiplicands
   logic [VW-1:0]    n_ff, d_ff, mn_ff, md_ff;
   logic [EXP_W-1:0] mag_ff, iter_ff;
   logic             neg_ff;

   // Prime table and its bookkeeping
   logic [PW-1:0]    prime_ff [MAX_BASES];
   logic [CNT_W-1:0] count_ff;
   logic [PW-1:0]    last_ff;
   logic [CNT_W-1:0] idx_ff;

   // Multiplier
   logic [VW-1:0]    mx_ff, my_ff;
   logic [VW-1:0]    pp_ff;
   logic [1:0]       psh_ff;
   logic [2*VW-1:0]  acc_ff, acc_in;
   logic [2:0]       mcnt_ff;
   logic             mbusy_ff, msel_ff, mdone_ff, movf_ff;
   logic [HALF_WIDTH-1:0] mx_half, my_half;

   // Divider
   logic [VW-1:0]     dn_ff, dd_ff;
   logic [PW-1:0]     rn_ff, rd_ff, dp_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   logic              dbusy_ff, ddone_ff;
   logic [PW:0]       tn, td;
   logic [PW-1:0]     rn_in, rd_in;
   logic              qn_bit, qd_bit;

   // Output register
   logic [VW-1:0]     num_out_ff, den_out_ff;
   logic [1:0]        status_ff;

   logic [EXP_W-1:0]  exp_abs;

   // Half-word operand selection for the current partial product
   always_comb begin
      mx_half = mcnt_ff[0] ? mx_ff[VW-1:HALF_WIDTH] : mx_ff[HALF_WIDTH-1:0];
      my_half = mcnt_ff[1] ? my_ff[VW-1:HALF_WIDTH] : my_ff[HALF_WIDTH-1:0];
      acc_in  = acc_ff + ((2*VW)'(pp_ff) << (HALF_WIDTH * int'(psh_ff)));
   end

   // One restoring step on both dividends
   always_comb begin
      tn     = {rn_ff, dn_ff[VW-1]};
      td     = {rd_ff, dd_ff[VW-1]};
      qn_bit = (tn >= {1'b0, dp_ff});
      qd_bit = (td >= {1'b0, dp_ff});
      rn_in  = qn_bit ? PW'(tn - {1'b0, dp_ff}) : tn[PW-1:0];
      rd_in  = qd_bit ? PW'(td - {1'b0, dp_ff}) : td[PW-1:0];
   end

   assign exp_abs = req_exponent[EXP_W-1] ? EXP_W'(-req_exponent) : EXP_W'(req_exponent);

   // Status
   always_comb begin
      sts.table_full = (count_ff == CNT_W'(MAX_BASES));
      sts.idx_end    = (idx_ff == count_ff);
      sts.both_zero  = (n_ff == '0) && (d_ff == '0);
      sts.exp_zero   = (mag_ff == '0);
      sts.exp_one    = (mag_ff == EXP_W'(1)) && !neg_ff;
      sts.iter_end   = (iter_ff >= mag_ff);
      sts.neg        = neg_ff;
      sts.mul_done   = mdone_ff;
      sts.mul_ovf    = movf_ff;
      sts.div_done   = ddone_ff;
      sts.rem_n_zero = (rn_ff == '0);
      sts.rem_d_zero = (rd_ff == '0);
   end

   // Control-state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         last_ff  <= PW'(1);
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         mdone_ff <= 1'b0;
         ddone_ff <= 1'b0;
         if (cmd.prime_store) begin
            count_ff <= count_ff + CNT_W'(1);
            last_ff  <= n_ff[PW-1:0];
         end
         if (cmd.mul_start) begin
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff && mcnt_ff == 3'd4) begin
            mbusy_ff <= 1'b0;
            mdone_ff <= 1'b1;
         end
         if (cmd.div_start) begin
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff && dcnt_ff == DCNT_W'(VW - 1)) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      // request capture; multiply/divide run the power loop once
      if (cmd.load) begin
         n_ff    <= req_num_a;
         d_ff    <= req_den_a;
         iter_ff <= EXP_W'(1);
         unique case (opcode_type'(req_opcode))
            OP_MUL: begin
               mn_ff <= req_num_b; md_ff <= req_den_b;
               mag_ff <= EXP_W'(2); neg_ff <= 1'b0;
            end
            OP_DIV: begin
               mn_ff <= req_den_b; md_ff <= req_num_b;
               mag_ff <= EXP_W'(2); neg_ff <= 1'b0;
            end
            OP_POW: begin
               mn_ff <= req_num_a; md_ff <= req_den_a;
               mag_ff <= exp_abs; neg_ff <= req_exponent[EXP_W-1];
            end
            default: begin
               mn_ff <= req_num_b; md_ff <= req_den_b;
               mag_ff <= EXP_W'(2); neg_ff <= 1'b0;
            end
         endcase
      end
      if (cmd.cand_init) begin
         n_ff <= VW'(PW'(last_ff + PW'(1)));
         d_ff <= VW'(1);
      end
      if (cmd.cand_next) begin
         n_ff <= VW'(PW'(n_ff[PW-1:0] + PW'(1)));
      end
      if (cmd.idx_clr || cmd.cand_init || cmd.cand_next) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (cmd.iter_inc) begin
         iter_ff <= iter_ff + EXP_W'(1);
      end
      if (cmd.swap) begin
         n_ff <= d_ff;
         d_ff <= n_ff;
      end
      if (cmd.set_unit) begin
         n_ff <= VW'(1);
         d_ff <= VW'(1);
      end
      if (cmd.div_take) begin
         n_ff <= dn_ff;
         d_ff <= dd_ff;
      end
      if (cmd.prime_store) begin
         prime_ff[idx_ff[IDX_W-1:0]] <= n_ff[PW-1:0];
      end

      // multiplier: four half-word products, each registered and added in the next cycle
      if (cmd.mul_start) begin
         mx_ff   <= cmd.mul_sel_d ? d_ff : n_ff;
         my_ff   <= cmd.mul_sel_d ? md_ff : mn_ff;
         msel_ff <= cmd.mul_sel_d;
         acc_ff  <= '0;
         mcnt_ff <= '0;
      end else if (mbusy_ff) begin
         mcnt_ff <= mcnt_ff + 3'd1;
         if (mcnt_ff != 3'd4) begin
            pp_ff  <= VW'(mx_half * my_half);
            psh_ff <= 2'(mcnt_ff[0]) + 2'(mcnt_ff[1]);
         end
         if (mcnt_ff != 3'd0) begin
            acc_ff <= acc_in;
         end
         if (mcnt_ff == 3'd4) begin
            movf_ff <= (acc_in[2*VW-1:VW] != '0);
            if (msel_ff) begin
               d_ff <= acc_in[VW-1:0];
            end else begin
               n_ff <= acc_in[VW-1:0];
            end
         end
      end

      // divider: one quotient bit per cycle on both parts
      if (cmd.div_start) begin
         dn_ff   <= n_ff;
         dd_ff   <= d_ff;
         rn_ff   <= '0;
         rd_ff   <= '0;
         dp_ff   <= prime_ff[idx_ff[IDX_W-1:0]];
         dcnt_ff <= '0;
      end else if (dbusy_ff) begin
         dn_ff   <= {dn_ff[VW-2:0], qn_bit};
         dd_ff   <= {dd_ff[VW-2:0], qd_bit};
         rn_ff   <= rn_in;
         rd_ff   <= rd_in;
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end

      // result register
      if (cmd.out_load) begin
         num_out_ff <= (cmd.out_code == ST_OK) ? n_ff : '0;
         den_out_ff <= (cmd.out_code == ST_OK) ? d_ff : '0;
         status_ff  <= cmd.out_code;
      end
   end

   assign rsp_num_out = num_out_ff;
   assign rsp_den_out = den_out_ff;
   assign rsp_status  = status_ff;

endmodule

>>> design/pcda_ctrl.sv
// Controller state machine sequencing trial division, products, powers and cancelling.
`timescale 1ns / 1ps
module pcda_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_opcode,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pcda_pkg::pcda_cmd_type cmd,
   input  pcda_pkg::pcda_sts_type sts
);
   import pcda_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_NB_CHECK, S_TRIAL, S_TRIAL_WAIT, S_PW_CHECK, S_PW_LOOP,
      S_MUL_N_WAIT, S_MUL_D_WAIT, S_CANCEL_START, S_CANCEL, S_C_WAIT, S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_xfer;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.out_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd.load = 1'b1;
               unique case (opcode_type'(req_opcode))
                  OP_NEW_BASE: state_in = S_NB_CHECK;
                  OP_POW:      state_in = S_PW_CHECK;
                  default:     state_in = S_PW_LOOP;
               endcase
            end
         end
         S_NB_CHECK: begin
            if (sts.table_full) begin
               code_in  = ST_FULL;
               state_in = S_FINISH;
            end else begin
               cmd.cand_init = 1'b1;
               state_in      = S_TRIAL;
            end
         end
         S_TRIAL: begin
            if (sts.idx_end) begin
               cmd.prime_store = 1'b1;
               code_in         = ST_OK;
               state_in        = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_TRIAL_WAIT;
            end
         end
         S_TRIAL_WAIT: begin
            if (sts.div_done) begin
               if (sts.rem_n_zero) begin
                  cmd.cand_next = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
               state_in = S_TRIAL;
            end
         end
         S_PW_CHECK: begin
            code_in = ST_OK;
            if (sts.exp_zero) begin
               cmd.set_unit = 1'b1;
               state_in     = S_FINISH;
            end else if (sts.exp_one) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_PW_LOOP;
            end
         end
         S_PW_LOOP: begin
            if (sts.iter_end) begin
               cmd.swap = sts.neg;
               state_in = S_CANCEL_START;
            end else begin
               cmd.mul_start = 1'b1;
               state_in      = S_MUL_N_WAIT;
            end
         end
         S_MUL_N_WAIT: begin
            if (sts.mul_done) begin
               if (sts.mul_ovf) begin
                  code_in  = ST_OVF;
                  state_in = S_FINISH;
               end else begin
                  cmd.mul_start = 1'b1;
                  cmd.mul_sel_d = 1'b1;
                  state_in      = S_MUL_D_WAIT;
               end
            end
         end
         S_MUL_D_WAIT: begin
            if (sts.mul_done) begin
               if (sts.mul_ovf) begin
                  code_in  = ST_OVF;
                  state_in = S_FINISH;
               end else begin
                  cmd.iter_inc = 1'b1;
                  state_in     = S_PW_LOOP;
               end
            end
         end
         S_CANCEL_START: begin
            code_in = ST_OK;
            if (sts.both_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = S_CANCEL;
            end
         end
         S_CANCEL: begin
            if (sts.idx_end) begin
               state_in = S_FINISH;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_C_WAIT;
            end
         end
         S_C_WAIT: begin
            if (sts.div_done) begin
               if (sts.rem_n_zero && sts.rem_d_zero) begin
                  cmd.div_take = 1'b1;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
               state_in = S_CANCEL;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         code_ff      <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> design/prime_coded_dimension_algebra_unit.sv
// Top level of the prime-coded dimension algebra unit.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | opcode, num_a, den_a, num_b, den_b, exponent
//   rsp_    | out       | rsp_valid/rsp_ready  | num_out, den_out, status
//
// One item at a time. Products run on the shared 32x32 multiplier, two per
// multiply/divide and two per power step. Each trial or cancelling division by a stored
// prime runs in the bit-serial divider; cancelling repeats it per factor.
// Reset clears the base count, sets the last prime to one and clears rsp_valid.
// A finished result waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
module prime_coded_dimension_algebra_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_opcode,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_num_a,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_den_a,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_num_b,
   input  logic [pcda_pkg::VALUE_WIDTH-1:0]    req_den_b,
   input  logic signed [pcda_pkg::EXP_W-1:0]   req_exponent,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcda_pkg::VALUE_WIDTH-1:0]    rsp_num_out,
   output logic [pcda_pkg::VALUE_WIDTH-1:0]    rsp_den_out,
   output logic [1:0]                          rsp_status
);
   import pcda_pkg::*;

   pcda_cmd_type cmd;
   pcda_sts_type sts;

   // Sequencer
   pcda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Arithmetic and storage
   pcda_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_opcode   (req_opcode),
      .req_num_a    (req_num_a),
      .req_den_a    (req_den_a),
      .req_num_b    (req_num_b),
      .req_den_b    (req_den_b),
      .req_exponent (req_exponent),
      .rsp_num_out  (rsp_num_out),
      .rsp_den_out  (rsp_den_out),
      .rsp_status   (rsp_status)
   );

endmodule

>>> tb/tb_prime_coded_dimension_algebra_unit.sv
// Self-checking testbench for the prime-coded dimension algebra unit.
`timescale 1ns / 1ps
module tb_prime_coded_dimension_algebra_unit;
   import pcda_pkg::*;

   localparam int IDLE_LIMIT = 60000;

   typedef logic [VALUE_WIDTH-1:0] value_type;

   typedef struct {
      opcode_type op;
      value_type  na, da, nb, db;
      int         pwr;
      bit         typed;
      value_type  en, ed;
      status_type es;
   } request_type;

   typedef struct {
      value_type  n, d;
      status_type st;
   } unit_result_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [1:0] req_opcode;
   value_type req_num_a, req_den_a, req_num_b, req_den_b;
   logic signed [EXP_W-1:0] req_exponent;
   logic rsp_valid, rsp_ready;
   value_type rsp_num_out, rsp_den_out;
   logic [1:0] rsp_status;

   // Shadow of the base table
   logic [PRIME_WIDTH-1:0] prime_table [MAX_BASES];
   int unsigned prime_count;
   logic [PRIME_WIDTH-1:0] newest_prime;

   request_type     directed_rows[$];
   unit_result_type pending_units[$];
   int  mismatches;
   bit  no_gaps;
   bit  stim_done;
   int  stall_cycles;

   prime_coded_dimension_algebra_unit i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Checked product: flags anything past VALUE_WIDTH bits
   function automatic value_type checked_mul(input value_type x, input value_type y,
                                             inout bit ovf);
      logic [2*VALUE_WIDTH-1:0] p;
      p = (2*VALUE_WIDTH)'(x) * (2*VALUE_WIDTH)'(y);
      if (p[2*VALUE_WIDTH-1:VALUE_WIDTH] != '0) begin
         ovf = 1'b1;
         return '0;
      end
      return p[VALUE_WIDTH-1:0];
   endfunction

   // Reduce by every stored prime, table order
   function automatic void reduce_unit(inout value_type n, inout value_type d);
      value_type p;
      if (n == 0 && d == 0) return;
      for (int i = 0; i < prime_count; i++) begin
         p = VALUE_WIDTH'(prime_table[i]);
         while (n % p == 0 && d % p == 0) begin
            n = n / p;
            d = d / p;
         end
      end
   endfunction

   // Expected result of one request; advances the shadow table
   function automatic unit_result_type unit_algebra(input request_type r);
      unit_result_type res;
      bit ovf, is_prime;
      int mag;
      value_type t;
      logic [PRIME_WIDTH-1:0] cand;
      ovf = 1'b0;
      res.n = '0;
      res.d = '0;
      res.st = ST_OK;
      case (r.op)
         OP_NEW_BASE: begin
            if (prime_count >= MAX_BASES) begin
               res.st = ST_FULL;
            end else begin
               cand = newest_prime;
               do begin
                  cand = cand + PRIME_WIDTH'(1);
                  is_prime = 1'b1;
                  for (int i = 0; i < prime_count; i++)
                     if (cand % prime_table[i] == 0) is_prime = 1'b0;
               end while (!is_prime);
               newest_prime = cand;
               prime_table[prime_count] = cand;
               prime_count++;
               res.n = VALUE_WIDTH'(cand);
               res.d = VALUE_WIDTH'(1);
            end
         end
         OP_MUL, OP_DIV: begin
            res.n = checked_mul(r.na, (r.op == OP_MUL) ? r.nb : r.db, ovf);
            res.d = checked_mul(r.da, (r.op == OP_MUL) ? r.db : r.nb, ovf);
            if (!ovf) reduce_unit(res.n, res.d);
         end
         default: begin
            if (r.pwr == 0) begin
               res.n = VALUE_WIDTH'(1);
               res.d = VALUE_WIDTH'(1);
            end else if (r.pwr == 1) begin
               res.n = r.na;
               res.d = r.da;
            end else begin
               mag = (r.pwr < 0) ? -r.pwr : r.pwr;
               res.n = r.na;
               res.d = r.da;
               for (int i = 1; i < mag && !ovf; i++) begin
                  res.n = checked_mul(res.n, r.na, ovf);
                  res.d = checked_mul(res.d, r.da, ovf);
               end
               if (!ovf) begin
                  if (r.pwr < 0) begin
                     t = res.n;
                     res.n = res.d;
                     res.d = t;
                  end
                  reduce_unit(res.n, res.d);
               end
            end
         end
      endcase
      if (ovf) begin
         res.n = '0;
         res.d = '0;
         res.st = ST_OVF;
      end
      return res;
   endfunction

   // Operand: mostly products of small primes, some raw 64-bit, rare zero
   function automatic value_type random_operand(input int max_factors);
      int primes[18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61};
      value_type v;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return '0;
      if (pick < 18) return {$urandom, $urandom};
      v = VALUE_WIDTH'(1);
      repeat ($urandom_range(0, max_factors))
         v = v * VALUE_WIDTH'(primes[$urandom_range(0, 17)]);
      return v;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.typed = 1'b0;
      r.op = (pick < 4) ? OP_NEW_BASE : (pick < 40) ? OP_MUL : (pick < 72) ? OP_DIV : OP_POW;
      r.na = random_operand(r.op == OP_POW ? 3 : 6);
      r.da = random_operand(r.op == OP_POW ? 3 : 6);
      r.nb = random_operand(6);
      r.db = random_operand(6);
      if ($urandom_range(0, 4) == 0) r.pwr = $signed($urandom_range(0, 127)) - 64;
      else r.pwr = $signed($urandom_range(0, 10)) - 5;
      return r;
   endfunction

   task automatic add_row(input opcode_type op, input value_type na, input value_type da,
                          input value_type nb, input value_type db, input int pwr,
                          input bit typed, input value_type en, input value_type ed,
                          input status_type es);
      request_type r;
      r = '{op, na, da, nb, db, pwr, typed, en, ed, es};
      directed_rows = {directed_rows, r};
   endtask

   // One transfer on the request side, with random gaps
   task automatic send_request(input request_type r);
      unit_result_type exp_res;
      int gap;
      gap = 0;
      if (!no_gaps) while ($urandom_range(0, 2) == 0) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= r.op;
      req_num_a    <= r.na;
      req_den_a    <= r.da;
      req_num_b    <= r.nb;
      req_den_b    <= r.db;
      req_exponent <= r.pwr[EXP_W-1:0];
      do @(posedge clock); while (!req_ready);
      exp_res = unit_algebra(r);
      if (r.typed) begin
         exp_res.n = r.en;
         exp_res.d = r.ed;
         exp_res.st = r.es;
      end
      pending_units = {pending_units, exp_res};
   endtask

   // Stimulus
   initial begin
      int firsts[16] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53};
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_NEW_BASE;
      req_num_a = '0;
      req_den_a = '0;
      req_num_b = '0;
      req_den_b = '0;
      req_exponent = '0;
      no_gaps = 1'b0;
      stim_done = 1'b0;
      prime_count = 0;
      newest_prime = PRIME_WIDTH'(1);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty table: nothing cancels
      add_row(OP_MUL, 6, 1, 1, 3, 0, 1, 6, 3, ST_OK);
      add_row(OP_POW, 4, 6, 0, 0, 0, 1, 1, 1, ST_OK);
      for (int i = 0; i < 16; i++)
         add_row(OP_NEW_BASE, 0, 0, 0, 0, 0, 1, VALUE_WIDTH'(firsts[i]), 1, ST_OK);
      // Table full leaves state alone
      add_row(OP_NEW_BASE, '1, '1, '1, '1, -1, 1, 0, 0, ST_FULL);
      add_row(OP_MUL, 64'h8000_0000_0000_0000, 1, 2, 1, 0, 1, 0, 0, ST_OVF);
      add_row(OP_POW, 12, 18, 0, 0, 1, 1, 12, 18, ST_OK);
      add_row(OP_POW, 1, 2, 0, 0, -64, 1, 0, 0, ST_OVF);
      add_row(OP_DIV, '1, '1, '1, '1, 63, 0, 0, 0, ST_OK);
      add_row(OP_POW, 12, 18, 0, 0, -3, 0, 0, 0, ST_OK);
      add_row(OP_MUL, 0, 0, 5, 7, 0, 0, 0, 0, ST_OK);
      add_row(OP_POW, 1, 1, 0, 0, 63, 0, 0, 0, ST_OK);
      add_row(OP_DIV, 2 * 3 * 59, 9, 61, 4, 0, 0, 0, 0, ST_OK);

      foreach (directed_rows[i]) send_request(directed_rows[i]);
      for (int i = 0; i < 1350; i++) begin
         no_gaps = (i >= 500 && i < 800);
         send_request(random_request());
      end
      req_valid <= 1'b0;
      no_gaps = 1'b0;
      stim_done = 1'b1;
   end

   // Result side: random stalls, compare each transfer with oldest expectation
   always @(posedge clock) begin
      unit_result_type exp_res;
      if (reset) begin
         rsp_ready <= 1'b0;
         mismatches <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_units.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("unexpected result %h/%h status %0d",
                           rsp_num_out, rsp_den_out, rsp_status);
            end else begin
               exp_res = pending_units.pop_front();
               if (rsp_num_out !== exp_res.n || rsp_den_out !== exp_res.d
                   || rsp_status !== exp_res.st) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: expected %h/%h status %0d, got %h/%h status %0d",
                              exp_res.n, exp_res.d, exp_res.st,
                              rsp_num_out, rsp_den_out, rsp_status);
               end
            end
         end
         rsp_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 2) != 0);
      end
   end

   // Watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= IDLE_LIMIT) begin
            $display("[prime_coded_dimension_algebra_unit] ERROR");
            $finish;
         end
      end
   end

   // End of run
   initial begin
      wait (stim_done);
      while (pending_units.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending_units.size() == 0) begin
         $display("[prime_coded_dimension_algebra_unit] OK");
      end else begin
         $display("[prime_coded_dimension_algebra_unit] ERROR");
      end
      $finish;
   end

endmodule

>>> prime_coded_dimension_algebra_unit.f
design/pcda_pkg.sv
design/pcda_datapath.sv
design/pcda_ctrl.sv
design/prime_coded_dimension_algebra_unit.sv
tb/tb_prime_coded_dimension_algebra_unit.sv
